// ===== rtl/scaled_bitmap_text_overlay_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text overlay block
// Clocked, reset-gated property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef SCALED_BITMAP_TEXT_OVERLAY_ASSERT_SVH
`define SCALED_BITMAP_TEXT_OVERLAY_ASSERT_SVH

// same-cycle implication
`define SBTO_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbto assertion failed");

// next-cycle implication
`define SBTO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbto assertion failed");

`endif

// ===== rtl/sbto_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbto_pkg
// Types, constants and font tables of the scaled 5x7 text overlay.
// ----------------------------------------------------------------------------
package sbto_pkg;

  localparam int unsigned TextSlots = 64;
  localparam int unsigned SlotIdxW  = $clog2(TextSlots);
  localparam int unsigned CodeW     = 8;
  localparam int unsigned FrameW    = 13;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic ActLoad  = 1'b0;
  localparam logic ActPixel = 1'b1;

  localparam logic [ApbAddrW-1:0] RegFrameWidth = 3'd0;

  localparam logic [15:0] FgColor = 16'hFFFF;
  localparam logic [15:0] BgColor = 16'h0000;

  localparam logic [2:0] FontW = 3'd5;
  localparam logic [5:0] FontH = 6'd7;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharC     = 8'h43;
  localparam logic [7:0] CharD     = 8'h44;
  localparam logic [7:0] CharE     = 8'h45;
  localparam logic [7:0] CharF     = 8'h46;
  localparam logic [7:0] CharP     = 8'h50;
  localparam logic [7:0] CharS     = 8'h53;
  localparam logic [7:0] CharColon = 8'h3A;

  localparam logic [FrameW-1:0] Fw4k = 13'd3840;
  localparam logic [FrameW-1:0] Fw2k = 13'd1920;

  localparam int unsigned RecipShift = 14;

  typedef struct packed {
    logic       action;
    logic [5:0] char_index;
    logic [7:0] char_code;
    logic [8:0] pixel_x;
    logic [5:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic        outside_panel;
    logic [8:0]  area_width;
    logic [5:0]  area_height;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  scale;
    logic [3:0]  pad_x;
    logic [2:0]  pad_y;
    logic [4:0]  advance;
    logic [10:0] recip;
    logic [8:0]  width;
    logic [5:0]  height;
  } layout_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic read;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  typedef logic [0:6][4:0] glyph_t;

  function automatic layout_t make_layout(logic [FrameW-1:0] fw);
    layout_t           l;
    logic [FrameW-1:0] w;
    if (fw >= Fw4k) begin
      l = '{scale: 3'd4, pad_x: 4'd8, pad_y: 3'd7, advance: 5'd24, recip: 11'd683,
            width: 9'd0, height: 6'd42};
      w = 13'd448;
    end else if (fw >= Fw2k) begin
      l = '{scale: 3'd3, pad_x: 4'd6, pad_y: 3'd6, advance: 5'd18, recip: 11'd911,
            width: 9'd0, height: 6'd32};
      w = 13'd336;
    end else begin
      l = '{scale: 3'd2, pad_x: 4'd4, pad_y: 3'd5, advance: 5'd12, recip: 11'd1366,
            width: 9'd0, height: 6'd24};
      w = 13'd224;
    end
    if (fw != '0 && w > fw) begin
      w = fw;
    end
    if (w <= 13'd2) begin
      w = 13'd2;
    end else begin
      w = w & ~13'd1;
    end
    l.width = w[8:0];
    return l;
  endfunction

  function automatic logic [4:0] glyph_slot(logic [7:0] code);
    logic [7:0] d;
    d = code - CharZero;
    if (code >= CharZero && code <= CharNine) begin
      return d[4:0];
    end
    unique case (code)
      CharC:     return 5'd10;
      CharD:     return 5'd11;
      CharE:     return 5'd12;
      CharF:     return 5'd13;
      CharP:     return 5'd14;
      CharS:     return 5'd15;
      CharColon: return 5'd16;
      default:   return 5'd17;
    endcase
  endfunction

  function automatic glyph_t glyph_rows(logic [4:0] slot);
    unique case (slot)
      5'd0:    return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      5'd1:    return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      5'd2:    return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      5'd3:    return {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      5'd4:    return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      5'd5:    return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      5'd6:    return {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      5'd7:    return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      5'd8:    return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      5'd9:    return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      5'd10:   return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      5'd11:   return {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
      5'd12:   return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      5'd13:   return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      5'd14:   return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      5'd15:   return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      5'd16:   return {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      default: return '0;
    endcase
  endfunction

endpackage

// ===== rtl/sbto_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbto_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbto_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sbto_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbto_ctrl
// Sequencer: capture, divide, store read and result hand-off per item.
// ----------------------------------------------------------------------------
module sbto_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sbto_pkg::status_t status_i,
  output sbto_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StCalc = 4'b0010,
    StRead = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = StRead;
      end
      StRead: begin
        cmd_o.read = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/sbto_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbto_dp
// Datapath: layout, text store, cell and glyph arithmetic, output register.
// ----------------------------------------------------------------------------
module sbto_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [sbto_pkg::FrameW-1:0]       raster_width_i,
  input  sbto_pkg::in_item_t                in_item_i,
  input  sbto_pkg::cmd_t                    cmd_i,
  output sbto_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sbto_pkg::out_item_t               out_item_o
);

  sbto_pkg::layout_t   layout_q;
  sbto_pkg::in_item_t  item_q;
  sbto_pkg::out_item_t out_q, out_d;
  logic                out_valid_q;

  logic [sbto_pkg::TextSlots-1:0] mask_q;

  logic        outside_q, outside_d;
  logic        margin_q, margin_d;
  logic [8:0]  dx_q, dx_d;
  logic [5:0]  dy;
  logic [19:0] cell_prod;
  logic [sbto_pkg::SlotIdxW-1:0] cell_q;
  logic [11:0] row_prod;
  logic [5:0]  row_q, row_d;
  logic [10:0] adv_prod;
  logic [8:0]  rem;
  logic [4:0]  over;
  logic [2:0]  col_q, col_d;
  logic [sbto_pkg::TextSlots-1:0] covered;
  logic        prefix_ok_q, prefix_ok_d;
  logic [7:0]  code;
  logic [4:0]  glyph_bits;
  logic        ink;
  logic        is_pixel;
  logic        load_we;

  assign is_pixel = (item_q.action == sbto_pkg::ActPixel);
  assign load_we  = cmd_i.capture && (in_item_i.action == sbto_pkg::ActLoad);

  sbto_ram #(
    .Width(sbto_pkg::CodeW),
    .Depth(sbto_pkg::TextSlots)
  ) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(in_item_i.char_index),
    .wdata_i(in_item_i.char_code),
    .re_i   (cmd_i.read),
    .raddr_i(cell_q),
    .rdata_o(code)
  );

  always_ff @(posedge clk_i) begin
    layout_q <= sbto_pkg::make_layout(raster_width_i);
  end

  // first stage: bounds, offsets, cell via reciprocal, glyph row
  always_comb begin
    outside_d = (item_q.pixel_x >= layout_q.width) || (item_q.pixel_y >= layout_q.height);
    margin_d  = (item_q.pixel_x < 9'(layout_q.pad_x)) || (item_q.pixel_y < 6'(layout_q.pad_y));
    dx_d      = item_q.pixel_x - 9'(layout_q.pad_x);
    dy        = item_q.pixel_y - 6'(layout_q.pad_y);
    cell_prod = 20'(dx_d) * 20'(layout_q.recip);
    row_prod  = 12'(dy) * 12'd43;
    unique case (layout_q.scale)
      3'd4:    row_d = dy >> 2;
      3'd3:    row_d = 6'(row_prod >> 7);
      default: row_d = dy >> 1;
    endcase
  end

  // second stage: column inside the cell, text-end check
  always_comb begin
    adv_prod = 11'(cell_q) * 11'(layout_q.advance);
    rem      = dx_q - adv_prod[8:0];
    for (int k = 0; k < 5; k++) begin
      over[k] = (rem >= 9'((k + 1) * int'(layout_q.scale)));
    end
    col_d = 3'($countones(over));
    for (int i = 0; i < sbto_pkg::TextSlots; i++) begin
      covered[i] = (i <= int'(cell_q));
    end
    prefix_ok_d = &(mask_q | ~covered);
  end

  always_comb begin
    glyph_bits = sbto_pkg::glyph_rows(sbto_pkg::glyph_slot(code))[row_q[2:0]];
    ink = is_pixel && !outside_q && !margin_q && (row_q < sbto_pkg::FontH) &&
          (col_q < sbto_pkg::FontW) && prefix_ok_q && glyph_bits[3'd4 - col_q];
    out_d.pixel_color   = ink ? sbto_pkg::FgColor : sbto_pkg::BgColor;
    out_d.outside_panel = is_pixel && outside_q;
    out_d.area_width    = layout_q.width;
    out_d.area_height   = layout_q.height;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmd_i.calc) begin
      outside_q <= outside_d;
      margin_q  <= margin_d;
      dx_q      <= dx_d;
      cell_q    <= cell_prod[sbto_pkg::RecipShift +: sbto_pkg::SlotIdxW];
      row_q     <= row_d;
    end
    if (cmd_i.read) begin
      col_q       <= col_d;
      prefix_ok_q <= prefix_ok_d;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_we) begin
        mask_q[in_item_i.char_index] <= (in_item_i.char_code != '0);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

endmodule

// ===== rtl/scaled_bitmap_text_overlay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_bitmap_text_overlay
// Scaled 5x7 font text panel: store text, answer one panel pixel per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o, in_item_i): a load item writes one
// character code into the 64-slot text store; a pixel item asks for the
// color of one panel pixel. Every item returns exactly one result item on
// the output channel (out_valid_o/out_ready_i, out_item_o), in order.
// Register raster_width (APB, address 0) sets font scale and panel size; it
// reaches the datapath through the raster_width and layout registers.
// An item is taken only while the sequencer is idle and passes through
// capture, cell divide, store read and result stages; no new item is taken
// until the last one has left its result stage. The text store read port
// and the four-step sequencer set this.
// A result waiting in the output register does not block the next accept;
// if the receiver still stalls when the next result is ready, the block
// holds in its result stage until the register frees.
// Reset empties the text (all slots NUL), clears raster_width and drops any
// pending result. No clearing pass: a per-slot present mask covers the store.
// ----------------------------------------------------------------------------
`include "scaled_bitmap_text_overlay_assert.svh"

module scaled_bitmap_text_overlay (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  sbto_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output sbto_pkg::out_item_t                 out_item_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sbto_pkg::ApbAddrW-1:0]       paddr,
  input  logic [sbto_pkg::ApbDataW-1:0]       pwdata,
  output logic [sbto_pkg::ApbDataW-1:0]       prdata,
  output logic                                pready
);

  logic [sbto_pkg::FrameW-1:0] raster_width_q;
  logic                        reg_hit;
  logic                        cfg_we;
  sbto_pkg::cmd_t              cmd;
  sbto_pkg::status_t           status;

  assign pready  = 1'b1;
  assign reg_hit = ({paddr[sbto_pkg::ApbAddrW-1:2], 2'b00} == sbto_pkg::RegFrameWidth);
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? sbto_pkg::ApbDataW'(raster_width_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raster_width_q <= '0;
    end else if (cfg_we) begin
      raster_width_q <= pwdata[sbto_pkg::FrameW-1:0];
    end
  end

  sbto_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  sbto_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .raster_width_i(raster_width_q),
    .in_item_i     (in_item_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o)
  );

  `SBTO_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `SBTO_ASSERT_IMPL(a_emit_into_free_reg, cmd.emit, !out_valid_o || out_ready_i)
  `SBTO_ASSERT_IMPL(a_outside_is_black, out_valid_o && out_item_o.outside_panel,
                    out_item_o.pixel_color == sbto_pkg::BgColor)
  `SBTO_ASSERT_IMPL(a_width_even, out_valid_o, !out_item_o.area_width[0])

endmodule

// ===== verif/scaled_bitmap_text_overlay_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_bitmap_text_overlay_test
// Checks the text overlay block against a local predictor of the panel.
// The text store and frame width are mirrored in the bench. Every accepted
// item yields one expected result, which is compared field by field with
// the block's result. Stimulus runs a directed part, a frame width sweep,
// random text lines with pixel queries under several idle and stall mixes,
// and a long output hold-off that stalls the input.
// ----------------------------------------------------------------------------
module scaled_bitmap_text_overlay_test;

  localparam int unsigned LineChars    = 18;
  localparam int unsigned PanelMinW    = 192;
  localparam int unsigned PanelMinH    = 24;
  localparam int unsigned BlankGlyph   = 17;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainLimit   = 20000;
  localparam logic [7:0]  CharNul      = 8'h00;
  localparam logic [7:0]  CharUnknown  = 8'h78;

  typedef struct {
    int unsigned scale;
    int unsigned pad_x;
    int unsigned pad_y;
    int unsigned advance;
    int unsigned width;
    int unsigned height;
  } panel_geom_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  sbto_pkg::in_item_t              in_item_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  sbto_pkg::out_item_t             out_item_o;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [sbto_pkg::ApbAddrW-1:0]   paddr;
  logic [sbto_pkg::ApbDataW-1:0]   pwdata;
  logic [sbto_pkg::ApbDataW-1:0]   prdata;
  logic                            pready;

  sbto_pkg::out_item_t             pending_answers[$];
  logic [7:0]                      text_copy [sbto_pkg::TextSlots];
  logic [sbto_pkg::FrameW-1:0]     raster_width_q = '0;
  int unsigned                     error_count = 0;
  int unsigned                     send_idle_pct = 0;
  int unsigned                     recv_stall_pct = 0;
  int unsigned                     hold_request = 0;
  int unsigned                     hold_taken = 0;
  int unsigned                     stall_left = 0;

  scaled_bitmap_text_overlay dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic panel_geom_t panel_geom(input logic [sbto_pkg::FrameW-1:0] fw);
    panel_geom_t g;
    int unsigned s;
    int unsigned tw;
    int unsigned th;
    g.scale   = (fw >= sbto_pkg::Fw4k) ? 4 : ((fw >= sbto_pkg::Fw2k) ? 3 : 2);
    s         = g.scale - 2;
    g.pad_x   = 4 + 2 * s;
    g.pad_y   = 5 + s;
    g.advance = 5 * g.scale + 2 + s;
    tw        = LineChars * g.advance + 2 * g.pad_x;
    th        = 7 * g.scale + 2 * g.pad_y;
    g.width   = (tw > PanelMinW) ? tw : PanelMinW;
    g.height  = (th > PanelMinH) ? th : PanelMinH;
    if (fw != '0 && g.width > 32'(fw)) begin
      g.width = 32'(fw);
    end
    g.width  = (g.width <= 2) ? 2 : (g.width & ~32'd1);
    g.height = (g.height <= 2) ? 2 : (g.height & ~32'd1);
    return g;
  endfunction

  function automatic logic [34:0] font_bits(input logic [7:0] code);
    int unsigned slot;
    if (code >= sbto_pkg::CharZero && code <= sbto_pkg::CharNine) begin
      slot = 32'(code - sbto_pkg::CharZero);
    end else begin
      case (code)
        sbto_pkg::CharC:     slot = 10;
        sbto_pkg::CharD:     slot = 11;
        sbto_pkg::CharE:     slot = 12;
        sbto_pkg::CharF:     slot = 13;
        sbto_pkg::CharP:     slot = 14;
        sbto_pkg::CharS:     slot = 15;
        sbto_pkg::CharColon: slot = 16;
        default:             slot = BlankGlyph;
      endcase
    end
    case (slot)
      0:       return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      1:       return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      2:       return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      3:       return {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      4:       return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      5:       return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      6:       return {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      7:       return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8:       return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      9:       return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      10:      return {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      11:      return {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
      12:      return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      13:      return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      14:      return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      15:      return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      16:      return {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      default: return '0;
    endcase
  endfunction

  function automatic logic glyph_ink(input panel_geom_t g, input int unsigned x,
                                     input int unsigned y);
    int unsigned dx;
    int unsigned dy;
    int unsigned row;
    int unsigned col;
    int unsigned cell_n;
    logic [34:0] rows;
    if (x < g.pad_x || y < g.pad_y) begin
      return 1'b0;
    end
    dx  = x - g.pad_x;
    dy  = y - g.pad_y;
    row = dy / g.scale;
    if (row >= 7) begin
      return 1'b0;
    end
    cell_n = dx / g.advance;
    col    = (dx % g.advance) / g.scale;
    if (col >= 5 || cell_n >= sbto_pkg::TextSlots) begin
      return 1'b0;
    end
    for (int unsigned i = 0; i <= cell_n; i++) begin
      if (text_copy[i] == CharNul) begin
        return 1'b0;
      end
    end
    rows = font_bits(text_copy[cell_n]);
    return rows[34 - 5 * row - col];
  endfunction

  function automatic sbto_pkg::out_item_t overlay_answer(input sbto_pkg::in_item_t it);
    sbto_pkg::out_item_t res;
    panel_geom_t g;
    g = panel_geom(raster_width_q);
    res = '0;
    res.pixel_color = sbto_pkg::BgColor;
    res.area_width  = g.width[8:0];
    res.area_height = g.height[5:0];
    if (it.action == sbto_pkg::ActLoad) begin
      text_copy[it.char_index] = it.char_code;
    end else if (32'(it.pixel_x) >= g.width || 32'(it.pixel_y) >= g.height) begin
      res.outside_panel = 1'b1;
    end else if (glyph_ink(g, 32'(it.pixel_x), 32'(it.pixel_y))) begin
      res.pixel_color = sbto_pkg::FgColor;
    end
    return res;
  endfunction

  function automatic sbto_pkg::in_item_t load_item(input int unsigned idx,
                                                   input logic [7:0] code);
    sbto_pkg::in_item_t it;
    it.action     = sbto_pkg::ActLoad;
    it.char_index = 6'(idx);
    it.char_code  = code;
    it.pixel_x    = 9'($urandom);
    it.pixel_y    = 6'($urandom);
    return it;
  endfunction

  function automatic sbto_pkg::in_item_t pixel_item(input int unsigned x, input int unsigned y);
    sbto_pkg::in_item_t it;
    it.action     = sbto_pkg::ActPixel;
    it.char_index = 6'($urandom);
    it.char_code  = 8'($urandom);
    it.pixel_x    = 9'(x);
    it.pixel_y    = 6'(y);
    return it;
  endfunction

  function automatic logic [7:0] pick_code();
    int unsigned n;
    n = $urandom_range(21);
    if (n < 10) begin
      return sbto_pkg::CharZero + 8'(n);
    end
    case (n)
      10:      return sbto_pkg::CharC;
      11:      return sbto_pkg::CharD;
      12:      return sbto_pkg::CharE;
      13:      return sbto_pkg::CharF;
      14:      return sbto_pkg::CharP;
      15:      return sbto_pkg::CharS;
      16:      return sbto_pkg::CharColon;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_item(input sbto_pkg::in_item_t it);
    logic taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (taken !== 1'b1);
    pending_answers.push_back(overlay_answer(it));
  endtask

  task automatic wait_idle();
    int unsigned n;
    n = 0;
    while (pending_answers.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_raster_width(input int unsigned value);
    logic done;
    in_valid_i <= 1'b0;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sbto_pkg::RegFrameWidth;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done = pready;
      @(posedge clk_i);
    end while (done !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    raster_width_q = value[sbto_pkg::FrameW-1:0];
    @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    panel_geom_t g;
    g = panel_geom(raster_width_q);
    send_item(pixel_item(g.pad_x + g.scale, g.pad_y));
    send_item(pixel_item(0, 0));
    send_item(pixel_item(511, 63));
  endtask

  task automatic test_directed_text();
    panel_geom_t g;
    int unsigned p;
    int unsigned q;
    int unsigned a;
    int unsigned s;
    g = panel_geom(raster_width_q);
    p = g.pad_x;
    q = g.pad_y;
    a = g.advance;
    s = g.scale;
    send_item(load_item(0, sbto_pkg::CharZero));
    send_item(load_item(1, sbto_pkg::CharNine));
    send_item(load_item(2, sbto_pkg::CharS));
    send_item(load_item(3, CharUnknown));
    send_item(load_item(4, sbto_pkg::CharColon));
    send_item(load_item(63, 8'hFF));
    send_item(load_item(5, CharNul));
    send_item(pixel_item(0, 0));
    send_item(pixel_item(p + s, q));
    send_item(pixel_item(p, q));
    send_item(pixel_item(p + 5 * s, q));
    send_item(pixel_item(p + a + s, q));
    send_item(pixel_item(p + 3 * a + s, q));
    send_item(pixel_item(p + 4 * a + 2 * s, q + s));
    send_item(pixel_item(p + s, q + 7 * s));
    send_item(pixel_item(p + 5 * a + s, q));
    send_item(load_item(5, sbto_pkg::CharZero + 8'd8));
    send_item(pixel_item(p + 5 * a + s, q));
    send_item(pixel_item(g.width - 1, g.height - 1));
    send_item(pixel_item(g.width, 0));
    send_item(pixel_item(0, g.height));
    send_item(pixel_item(511, 63));
  endtask

  task automatic test_raster_width_sweep();
    int unsigned widths [15];
    panel_geom_t g;
    widths = '{0, 1, 2, 3, 191, 223, 224, 225, 1919, 1920, 335, 3839, 3840, 447, 8191};
    foreach (widths[i]) begin
      write_raster_width(widths[i]);
      g = panel_geom(raster_width_q);
      send_item(pixel_item(g.pad_x + g.scale, g.pad_y));
      send_item(pixel_item(g.width - 1, g.height - 1));
      send_item(pixel_item(g.width, 0));
      send_item(pixel_item(0, g.height));
    end
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_items);
    panel_geom_t g;
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    int unsigned fw;
    case ($urandom_range(3))
      0:       fw = 0;
      1:       fw = $urandom_range(1, 1919);
      2:       fw = $urandom_range(1920, 3839);
      default: fw = $urandom_range(3840, 8191);
    endcase
    write_raster_width(fw);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    g = panel_geom(raster_width_q);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 7) begin
        len = $urandom_range(LineChars);
        for (int unsigned i = 0; i < len; i++) begin
          send_item(load_item(i, pick_code()));
        end
        if ($urandom_range(3) != 0) begin
          send_item(load_item(len, CharNul));
        end
        k = $urandom_range(4, 12);
        repeat (k) begin
          send_item(pixel_item($urandom_range((g.width + 4 > 511) ? 511 : g.width + 4),
                               $urandom_range((g.height + 2 > 63) ? 63 : g.height + 2)));
        end
        sent += len + 1 + k;
      end else begin
        if ($urandom_range(1) != 0) begin
          send_item(load_item($urandom_range(63), 8'($urandom_range(255))));
        end else begin
          send_item(pixel_item($urandom_range(511), $urandom_range(63)));
        end
        sent++;
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    panel_geom_t g;
    g = panel_geom(raster_width_q);
    hold_request++;
    repeat (24) begin
      send_item(pixel_item($urandom_range(g.width - 1), $urandom_range(g.height - 1)));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_taken != hold_request) begin
        hold_taken = hold_request;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(negedge clk_i) begin : check_result
    sbto_pkg::out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", out_item_o));
      end else begin
        want = pending_answers.pop_front();
        if (out_item_o.pixel_color !== want.pixel_color) begin
          report_mismatch($sformatf("pixel_color got %h want %h",
                                    out_item_o.pixel_color, want.pixel_color));
        end
        if (out_item_o.outside_panel !== want.outside_panel) begin
          report_mismatch($sformatf("outside_panel got %b want %b",
                                    out_item_o.outside_panel, want.outside_panel));
        end
        if (out_item_o.area_width !== want.area_width) begin
          report_mismatch($sformatf("area_width got %0d want %0d",
                                    out_item_o.area_width, want.area_width));
        end
        if (out_item_o.area_height !== want.area_height) begin
          report_mismatch($sformatf("area_height got %0d want %0d",
                                    out_item_o.area_height, want.area_height));
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    foreach (text_copy[i]) text_copy[i] = CharNul;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_directed_text();
    test_raster_width_sweep();
    test_random_traffic(0, 0, 70);
    test_random_traffic(64, 0, 70);
    test_random_traffic(0, 64, 70);
    test_random_traffic(20, 20, 70);
    test_backpressure();
    in_valid_i <= 1'b0;
    wait_idle();
    if (pending_answers.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== scaled_bitmap_text_overlay.f =====
+incdir+rtl
rtl/sbto_pkg.sv
rtl/sbto_ram.sv
rtl/sbto_ctrl.sv
rtl/sbto_dp.sv
rtl/scaled_bitmap_text_overlay.sv
verif/scaled_bitmap_text_overlay_test.sv
